// ----- rtl/core/clt_pkg.sv -----
// Shared types and helpers for the command line tokenizer.
// Result beat layout, per-byte step bundle and the token limit ceiling.
// No dependencies.
package clt_pkg;

	localparam logic [10:0] MAX_TOKENS = 11'd1024;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_EOL  = 2'd2
	} kind_t;

	typedef struct packed {
		logic        last;
		logic [10:0] token_count;
		logic [9:0]  token_index;
		logic [7:0]  out_char;
		kind_t       kind;
	} result_t;

	// Up to three results from one byte, with their number.
	typedef struct packed {
		result_t [2:0] res;
		logic [1:0]    cnt;
	} step_t;

	function automatic result_t make_result(kind_t k, logic [7:0] ch, logic [9:0] idx,
		logic [10:0] count);
		result_t r;
		r.last        = 1'b0;
		r.token_count = count;
		r.token_index = idx;
		r.out_char    = ch;
		r.kind        = k;
		return r;
	endfunction

	function automatic logic [9:0] index_of(logic [10:0] tokens);
		logic [10:0] d;
		d = tokens - 11'd1;
		return d[9:0];
	endfunction

endpackage

// ----- rtl/core/command_line_tokenizer.sv -----
// Streaming command line tokenizer, one byte in per beat.
// Slave channel: s_axis_tdata carries one byte of the line; byte zero ends it.
// Master channel: one result per beat; tdata holds kind, character, token
// index and token count, tlast marks the final result caused by a byte.
// Config: token_limit_we writes token_limit_wdata into the token limit.
// A byte's results pass through the input register and then the result queue.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver takes every beat; the result queue drains one beat per cycle, so a byte
// causing two or three results (end of token, end of line) holds the input back.
// The input register steps the parser only when the queue has room for three.
// Reset clears the parse state, empties the queue and sets the limit to 1024.
// When the receiver stalls the queue fills, the input register holds its byte
// and s_axis_tready falls; nothing is lost.
// Depends on clt_pkg, clt_parse and clt_resq.
module command_line_tokenizer import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,      // [7:0] char_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,      // [1:0] kind, [9:2] out_char,
	                                       // [19:10] token_index, [30:20] token_count
	output logic        m_axis_tlast,
	input  logic        token_limit_we,
	input  logic [10:0] token_limit_wdata
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       room;
	logic       advance;
	step_t      step_res;
	result_t    head;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
	end

	clt_parse u_parse (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.char_in           (char_s1),
		.token_limit_we    (token_limit_we),
		.token_limit_wdata (token_limit_wdata),
		.step_out          (step_res)
	);

	clt_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (step_res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (head)
	);

	assign m_axis_tdata = {1'b0, head.token_count, head.token_index, head.out_char, head.kind};
	assign m_axis_tlast = head.last;

endmodule

// ----- rtl/core/clt_parse.sv -----
// Tokenizer state and the single-pass byte step producing up to three results.
// Holds the token limit register. Depends on clt_pkg.
module clt_parse import clt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  char_in,
	input  logic        token_limit_we,
	input  logic [10:0] token_limit_wdata,
	output step_t       step_out
);

	typedef enum logic [2:0] {
		M_BETWEEN = 3'd0,
		M_PLAIN   = 3'd1,
		M_QUOTED  = 3'd2,
		M_BLOCK   = 3'd3,
		M_IGNORE  = 3'd4
	} mode_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	mode_t       mode_q, mode_d;
	logic        slash_q, slash_d;
	logic        star_q, star_d;
	logic [10:0] tok_q, tok_d;
	logic [10:0] limit_q;
	logic [10:0] lim;
	logic        consumed;
	logic [1:0]  n;
	result_t [2:0] res;

	assign lim = (limit_q > MAX_TOKENS) ? MAX_TOKENS : limit_q;

	always_comb begin
		mode_d   = mode_q;
		slash_d  = slash_q;
		star_d   = star_q;
		tok_d    = tok_q;
		consumed = 1'b0;
		n        = 2'd0;
		res      = '0;

		if (slash_d) begin
			slash_d = 1'b0;
			if (mode_d == M_BETWEEN) begin
				if (char_in == CH_SLASH) begin
					mode_d   = M_IGNORE;
					consumed = 1'b1;
				end else if (char_in == CH_STAR) begin
					mode_d   = M_BLOCK;
					star_d   = 1'b1;
					consumed = 1'b1;
				end else if (tok_d >= lim) begin
					mode_d = M_IGNORE;
				end else begin
					tok_d  = tok_d + 11'd1;
					mode_d = M_PLAIN;
					res[n] = make_result(KIND_CHAR, CH_SLASH, index_of(tok_d), '0);
					n      = n + 2'd1;
				end
			end else if (mode_d == M_PLAIN) begin
				if (char_in == CH_SLASH || char_in == CH_STAR) begin
					res[n]   = make_result(KIND_END, '0, index_of(tok_d), '0);
					n        = n + 2'd1;
					consumed = 1'b1;
					if (char_in == CH_SLASH) begin
						mode_d = M_IGNORE;
					end else begin
						mode_d = M_BLOCK;
						star_d = 1'b1;
					end
				end else begin
					res[n] = make_result(KIND_CHAR, CH_SLASH, index_of(tok_d), '0);
					n      = n + 2'd1;
				end
			end
		end

		if (char_in == CH_NUL) begin
			if (mode_d == M_PLAIN || mode_d == M_QUOTED) begin
				res[n] = make_result(KIND_END, '0, index_of(tok_d), '0);
				n      = n + 2'd1;
			end
			res[n]  = make_result(KIND_EOL, '0, '0, tok_d);
			n       = n + 2'd1;
			mode_d  = M_BETWEEN;
			slash_d = 1'b0;
			star_d  = 1'b0;
			tok_d   = '0;
		end else if (!consumed) begin
			unique case (mode_d)
				M_BETWEEN: begin
					if (char_in > CH_SPACE) begin
						if (char_in == CH_SLASH) begin
							slash_d = 1'b1;
						end else if (tok_d >= lim) begin
							mode_d = M_IGNORE;
						end else begin
							tok_d = tok_d + 11'd1;
							if (char_in == CH_QUOTE) begin
								mode_d = M_QUOTED;
							end else begin
								mode_d = M_PLAIN;
								res[n] = make_result(KIND_CHAR, char_in, index_of(tok_d), '0);
								n      = n + 2'd1;
							end
						end
					end
				end
				M_PLAIN: begin
					if (char_in <= CH_SPACE || char_in == CH_QUOTE) begin
						res[n] = make_result(KIND_END, '0, index_of(tok_d), '0);
						n      = n + 2'd1;
						mode_d = M_BETWEEN;
						if (char_in == CH_QUOTE) begin
							if (tok_d >= lim) begin
								mode_d = M_IGNORE;
							end else begin
								tok_d  = tok_d + 11'd1;
								mode_d = M_QUOTED;
							end
						end
					end else if (char_in == CH_SLASH) begin
						slash_d = 1'b1;
					end else begin
						res[n] = make_result(KIND_CHAR, char_in, index_of(tok_d), '0);
						n      = n + 2'd1;
					end
				end
				M_QUOTED: begin
					if (char_in == CH_QUOTE) begin
						res[n] = make_result(KIND_END, '0, index_of(tok_d), '0);
						n      = n + 2'd1;
						mode_d = M_BETWEEN;
					end else begin
						res[n] = make_result(KIND_CHAR, char_in, index_of(tok_d), '0);
						n      = n + 2'd1;
					end
				end
				M_BLOCK: begin
					if (star_d && char_in == CH_SLASH) begin
						mode_d = M_BETWEEN;
						star_d = 1'b0;
					end else begin
						star_d = (char_in == CH_STAR);
					end
				end
				default: begin
				end
			endcase
		end

		unique case (n)
			2'd1:    res[0].last = 1'b1;
			2'd2:    res[1].last = 1'b1;
			2'd3:    res[2].last = 1'b1;
			default: begin
			end
		endcase

		step_out.res = res;
		step_out.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BETWEEN;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			tok_q   <= '0;
			limit_q <= MAX_TOKENS;
		end else begin
			if (step) begin
				mode_q  <= mode_d;
				slash_q <= slash_d;
				star_q  <= star_d;
				tok_q   <= tok_d;
			end
			if (token_limit_we) begin
				limit_q <= token_limit_wdata;
			end
		end
	end

endmodule

// ----- rtl/core/clt_resq.sv -----
// Four-entry result queue: takes up to three results per cycle, gives one
// per cycle while out_ready is high. Depends on clt_pkg.
module clt_resq import clt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  step_t   push_data,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t    mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] push_n;

	assign pop       = out_valid && out_ready;
	assign push_n    = push ? push_data.cnt : 2'd0;
	assign room      = (count_q <= 3'd1);
	assign out_valid = (count_q != 3'd0);
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_n) begin
				mem_q[wp_q + 2'(i)] <= push_data.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + push_n;
			rp_q    <= rp_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

endmodule
